FILE: rtl/core/edfs_pkg.sv
// ============================================================================
// edfs_pkg: shared types and constants of the EDF scheduler
// Field widths, request and status codes, and the memory command struct.
// ============================================================================
package edfs_pkg;

  // Field widths
  localparam int TASK_ID_W = 8;
  localparam int BURST_W   = 16;
  localparam int TIME_W    = 32;
  localparam int FACTOR_W  = 4;
  localparam int STATUS_W  = 2;

  // Deadline factor after reset
  localparam logic [FACTOR_W-1:0] FACTOR_RESET = 4'd2;

  // Request types
  localparam logic REQ_ARRIVAL = 1'b0;
  localparam logic REQ_TICK    = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_ACCEPT = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RAN    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_IDLE   = 2'd3;

  // Write commands to the slot store
  typedef struct packed {
    logic fill;  // store a new task in every field
    logic dec;   // write back a decremented remaining time
  } slot_cmd_t;

endpackage

FILE: rtl/core/edfs_ifs.sv
// ============================================================================
// edfs channel interfaces
// Request, response and configuration channels with valid/ready handshake.
// ============================================================================

// Request channel: task arrival or time tick
interface edfs_req_if;
  import edfs_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic [TASK_ID_W-1:0] task_id;
  logic [BURST_W-1:0]   burst_length;

  modport source(output valid, output req_type, output task_id, output burst_length,
                 input ready);
  modport sink(input valid, input req_type, input task_id, input burst_length,
               output ready);
endinterface

// Response channel: one result per request
interface edfs_rsp_if;
  import edfs_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [TASK_ID_W-1:0] run_id;
  logic                 completed;
  logic [TIME_W-1:0]    turnaround;
  logic [TIME_W-1:0]    time_now;

  modport source(output valid, output status, output run_id, output completed,
                 output turnaround, output time_now, input ready);
  modport sink(input valid, input status, input run_id, input completed,
               input turnaround, input time_now, output ready);
endinterface

// Configuration channel: deadline factor write
interface edfs_cfg_if;
  import edfs_pkg::*;
  logic                valid;
  logic                ready;
  logic [FACTOR_W-1:0] deadline_factor;

  modport source(output valid, output deadline_factor, input ready);
  modport sink(input valid, input deadline_factor, output ready);
endinterface

FILE: rtl/core/edfs_slot_store.sv
// ============================================================================
// edfs_slot_store: task table memories
// One memory per slot field, one write address and registered reads.
// Deadlines have their own read address for the scan.
// ============================================================================
module edfs_slot_store #(
  parameter int MAX_TASKS = 16
) (
  input  logic                                   clk,
  input  edfs_pkg::slot_cmd_t                    cmd,
  input  logic [$clog2(MAX_TASKS)-1:0]           wr_addr,
  input  logic [edfs_pkg::TASK_ID_W-1:0]         fill_task,
  input  logic [edfs_pkg::BURST_W-1:0]           fill_rem,
  input  logic [edfs_pkg::TIME_W-1:0]            fill_dl,
  input  logic [edfs_pkg::TIME_W-1:0]            fill_arr,
  input  logic [edfs_pkg::BURST_W-1:0]           dec_rem,
  input  logic [$clog2(MAX_TASKS)-1:0]           dl_addr,
  output logic [edfs_pkg::TIME_W-1:0]            dl_rd,
  input  logic [$clog2(MAX_TASKS)-1:0]           rd_addr,
  output logic [edfs_pkg::TASK_ID_W-1:0]         task_rd,
  output logic [edfs_pkg::BURST_W-1:0]           rem_rd,
  output logic [edfs_pkg::TIME_W-1:0]            arr_rd
);
  import edfs_pkg::*;

  logic [TASK_ID_W-1:0] task_mem [MAX_TASKS];
  logic [BURST_W-1:0]   rem_mem  [MAX_TASKS];
  logic [TIME_W-1:0]    dl_mem   [MAX_TASKS];
  logic [TIME_W-1:0]    arr_mem  [MAX_TASKS];

  // Writes: a fill stores all fields, a decrement only the remaining time
  always_ff @(posedge clk) begin
    if (cmd.fill) begin
      task_mem[wr_addr] <= fill_task;
      dl_mem[wr_addr]   <= fill_dl;
      arr_mem[wr_addr]  <= fill_arr;
    end
    if (cmd.fill || cmd.dec) begin
      rem_mem[wr_addr] <= cmd.fill ? fill_rem : dec_rem;
    end
  end

  // Registered reads
  always_ff @(posedge clk) begin
    dl_rd   <= dl_mem[dl_addr];
    task_rd <= task_mem[rd_addr];
    rem_rd  <= rem_mem[rd_addr];
    arr_rd  <= arr_mem[rd_addr];
  end

endmodule

FILE: rtl/core/edf_preemptive_scheduler.sv
// ============================================================================
// edf_preemptive_scheduler: preemptive earliest-deadline-first scheduler
// Task table of MAX_TASKS slots, arrival and tick requests, one result each.
// ============================================================================
// One request is handled at a time; req.ready is high only while the block
// is idle. An arrival walks the valid bits one slot per cycle until the
// lowest free slot, or through the last slot when the table is full. A tick
// streams every stored deadline through a single shared 32-bit comparator,
// one slot per cycle through registered deadline reads, then makes the
// preemption decision, updates the chosen task and stages the result once
// the output register is free; an idle tick skips the update. The sequencer
// returns to idle on the edge that stages the result, so the next request can
// be accepted from the following cycle on. The result sits in an output
// register, so the next request is taken while it waits. Deadline factor
// writes are taken at any time and are meant for an idle block.
// ============================================================================
module edf_preemptive_scheduler #(
  parameter int MAX_TASKS = 16
) (
  input logic       clk,
  input logic       rst,
  edfs_req_if.sink  req,
  edfs_rsp_if.source rsp,
  edfs_cfg_if.sink  cfg
);
  import edfs_pkg::*;

  localparam int SLOT_W = $clog2(MAX_TASKS);
  localparam int CNT_W  = $clog2(MAX_TASKS + 1);
  localparam int PROD_W = BURST_W + FACTOR_W;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_TASKS - 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(MAX_TASKS);
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ASCAN = 6'b000010,
    S_TSCAN = 6'b000100,
    S_TPICK = 6'b001000,
    S_TRUN  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  // Control state
  state_t                state;
  logic [FACTOR_W-1:0]   factor;
  logic [MAX_TASKS-1:0]  slot_valid;
  logic [TIME_W-1:0]     now_count;
  logic                  running_valid;
  logic [SLOT_W-1:0]     running_slot;
  logic [CNT_W-1:0]      cnt;
  logic                  pipe_vld;
  logic                  best_found;
  logic                  o_vld;

  // Payload
  logic [TASK_ID_W-1:0]  task_q;
  logic [BURST_W-1:0]    burst_q;
  logic [SLOT_W-1:0]     pipe_idx;
  logic [SLOT_W-1:0]     best_idx;
  logic [TIME_W-1:0]     best_dl;
  logic [TIME_W-1:0]     run_dl;
  logic [STATUS_W-1:0]   res_status;
  logic [TASK_ID_W-1:0]  res_run_id;
  logic                  res_completed;
  logic [TIME_W-1:0]     res_turn;
  logic [TIME_W-1:0]     res_time;
  logic [STATUS_W-1:0]   o_status;
  logic [TASK_ID_W-1:0]  o_run_id;
  logic                  o_completed;
  logic [TIME_W-1:0]     o_turn;
  logic [TIME_W-1:0]     o_time;

  // Datapath nets
  logic [SLOT_W-1:0]     scan_slot;
  logic [TIME_W-1:0]     cmp_a;
  logic [TIME_W-1:0]     cmp_b;
  logic                  cmp_lt;
  logic [PROD_W-1:0]     dl_prod;
  logic [TIME_W:0]       dl_sum;
  logic [TIME_W-1:0]     dl_new;
  logic [TIME_W-1:0]     now_inc;
  logic                  run_ok;
  logic                  keep_run;
  logic                  pick_any;
  logic [SLOT_W-1:0]     pick_slot;
  logic                  last_unit;
  logic                  out_free;
  slot_cmd_t             cmd;
  logic [SLOT_W-1:0]     wr_addr;
  logic [TIME_W-1:0]     dl_rd;
  logic [TASK_ID_W-1:0]  task_rd;
  logic [BURST_W-1:0]    rem_rd;
  logic [TIME_W-1:0]     arr_rd;

  assign scan_slot = cnt[SLOT_W-1:0];

  // Shared deadline comparator: scan against best, then best against running
  always_comb begin
    if (state == S_TPICK) begin
      cmp_a = best_dl;
      cmp_b = run_dl;
    end else begin
      cmp_a = dl_rd;
      cmp_b = best_dl;
    end
  end
  assign cmp_lt = cmp_a < cmp_b;

  // New deadline, saturating
  assign dl_prod = burst_q * factor;
  assign dl_sum  = {1'b0, now_count} + (TIME_W + 1)'(dl_prod);
  assign dl_new  = dl_sum[TIME_W] ? TIME_MAX : dl_sum[TIME_W-1:0];

  // Saturating time step
  assign now_inc = (now_count == TIME_MAX) ? now_count : now_count + 1'b1;

  // Preemption decision: keep the running task unless a strictly earlier one waits
  assign run_ok    = running_valid && slot_valid[running_slot];
  assign keep_run  = run_ok && !cmp_lt;
  assign pick_any  = keep_run || best_found;
  assign pick_slot = keep_run ? running_slot : best_idx;

  assign last_unit = rem_rd <= BURST_W'(1);
  assign out_free  = !o_vld || rsp.ready;

  // Slot store control
  always_comb begin
    cmd.fill = (state == S_ASCAN) && !slot_valid[scan_slot];
    cmd.dec  = (state == S_TRUN) && !last_unit;
    wr_addr  = (state == S_ASCAN) ? scan_slot : running_slot;
  end

  edfs_slot_store #(
    .MAX_TASKS(MAX_TASKS)
  ) u_store (
    .clk      (clk),
    .cmd      (cmd),
    .wr_addr  (wr_addr),
    .fill_task(task_q),
    .fill_rem (burst_q),
    .fill_dl  (dl_new),
    .fill_arr (now_count),
    .dec_rem  (rem_rd - 1'b1),
    .dl_addr  (scan_slot),
    .dl_rd    (dl_rd),
    .rd_addr  (pick_slot),
    .task_rd  (task_rd),
    .rem_rd   (rem_rd),
    .arr_rd   (arr_rd)
  );

  // Configuration register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      factor <= FACTOR_RESET;
    end else if (cfg.valid) begin
      factor <= cfg.deadline_factor;
    end
  end

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      slot_valid    <= '0;
      now_count     <= '0;
      running_valid <= 1'b0;
      running_slot  <= '0;
      cnt           <= '0;
      pipe_vld      <= 1'b0;
      best_found    <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            cnt        <= '0;
            pipe_vld   <= 1'b0;
            best_found <= 1'b0;
            state      <= (req.req_type == REQ_TICK) ? S_TSCAN : S_ASCAN;
          end
        end
        S_ASCAN: begin
          if (!slot_valid[scan_slot]) begin
            slot_valid[scan_slot] <= 1'b1;
            state                 <= S_DONE;
          end else if (cnt == CNT_LAST) begin
            state <= S_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_TSCAN: begin
          pipe_vld <= (cnt != CNT_END);
          if (pipe_vld && slot_valid[pipe_idx] && (!best_found || cmp_lt)) begin
            best_found <= 1'b1;
          end
          if (cnt == CNT_END) begin
            state <= S_TPICK;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_TPICK: begin
          if (pick_any) begin
            running_valid <= 1'b1;
            running_slot  <= pick_slot;
            state         <= S_TRUN;
          end else begin
            running_valid <= 1'b0;
            now_count     <= now_inc;
            state         <= S_DONE;
          end
        end
        S_TRUN: begin
          now_count <= now_inc;
          if (last_unit) begin
            slot_valid[running_slot] <= 1'b0;
            running_valid            <= 1'b0;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Scan registers and result staging
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          task_q  <= req.task_id;
          burst_q <= (req.burst_length == '0) ? BURST_W'(1) : req.burst_length;
        end
      end
      S_ASCAN: begin
        res_status    <= slot_valid[scan_slot] ? ST_FULL : ST_ACCEPT;
        res_run_id    <= '0;
        res_completed <= 1'b0;
        res_turn      <= '0;
        res_time      <= now_count;
      end
      S_TSCAN: begin
        pipe_idx <= scan_slot;
        if (pipe_vld && slot_valid[pipe_idx] && (!best_found || cmp_lt)) begin
          best_idx <= pipe_idx;
          best_dl  <= dl_rd;
        end
        if (pipe_vld && (pipe_idx == running_slot)) begin
          run_dl <= dl_rd;
        end
      end
      S_TPICK: begin
        res_status    <= ST_IDLE;
        res_run_id    <= '0;
        res_completed <= 1'b0;
        res_turn      <= '0;
        res_time      <= now_inc;
      end
      S_TRUN: begin
        res_status    <= ST_RAN;
        res_run_id    <= task_rd;
        res_completed <= last_unit;
        res_turn      <= last_unit ? now_inc - arr_rd : '0;
        res_time      <= now_inc;
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      o_vld <= 1'b1;
    end else if (rsp.ready) begin
      o_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      o_status    <= res_status;
      o_run_id    <= res_run_id;
      o_completed <= res_completed;
      o_turn      <= res_turn;
      o_time      <= res_time;
    end
  end

  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = o_vld;
  assign rsp.status     = o_status;
  assign rsp.run_id     = o_run_id;
  assign rsp.completed  = o_completed;
  assign rsp.turnaround = o_turn;
  assign rsp.time_now   = o_time;

  // A request starts the sequencer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state != S_IDLE))
    else $error("sequencer stayed idle after a request transaction");

  // Results are only produced from the done state
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(o_vld) |-> $past(state == S_DONE))
    else $error("result appeared outside the done state");

  // Between requests a running mark always points at a stored task
  a_running_slot_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && running_valid) |-> slot_valid[running_slot])
    else $error("running mark on a free slot");

  // Time never goes backwards
  a_time_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (now_count >= $past(now_count)))
    else $error("time counter decreased");

endmodule

FILE: tb/edf_preemptive_scheduler_tb.sv
// ============================================================================
// edf_preemptive_scheduler_tb: self-checking bench for the EDF scheduler
// Drives arrival and tick requests through the request channel and predicts
// every response with a cycle-free model of the task table. The model covers
// deadline ordering, preemption, completion and turnaround. Responses are
// checked in order, field by field. The run starts with a short directed
// block: idle tick, zero burst, full table. Random phases follow, one per
// deadline factor, with random gaps and stalls on both channels and one long
// back-pressure stretch.
// ============================================================================
module edf_preemptive_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import edfs_pkg::*;

  localparam int NUM_SLOTS      = 16;
  localparam int WAIT_MAX       = 19;
  localparam int HOLD_AT        = 500;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_ITEMS   = 1775;
  localparam int NUM_PHASES     = 5;
  localparam int DRAIN_CYCLES   = 30;
  localparam int REPORT_MAX     = 10;

  typedef struct packed {
    logic                 req_type;
    logic [TASK_ID_W-1:0] task_id;
    logic [BURST_W-1:0]   burst_length;
  } sched_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [TASK_ID_W-1:0] run_id;
    logic                 completed;
    logic [TIME_W-1:0]    turnaround;
    logic [TIME_W-1:0]    time_now;
  } sched_rsp_t;

  logic clk = 1'b0;
  logic rst;

  edfs_req_if req_ch ();
  edfs_rsp_if rsp_ch ();
  edfs_cfg_if cfg_ch ();

  edf_preemptive_scheduler #(.MAX_TASKS(NUM_SLOTS)) DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  initial forever #5 clk = ~clk;

  // Model of the task table
  logic                 tbl_used     [NUM_SLOTS];
  logic [TASK_ID_W-1:0] tbl_id       [NUM_SLOTS];
  logic [BURST_W-1:0]   tbl_left     [NUM_SLOTS];
  logic [TIME_W-1:0]    tbl_deadline [NUM_SLOTS];
  logic [TIME_W-1:0]    tbl_arrival  [NUM_SLOTS];
  logic [TIME_W-1:0]    clock_now;
  logic                 cpu_busy;
  int                   cpu_slot;
  logic [FACTOR_W-1:0]  factor_model;

  // Stimulus backlog and predicted responses
  sched_req_t req_backlog [$];
  sched_rsp_t sched_result_q [$];
  sched_req_t req_live;

  // Idle control, one entry per side: 0 sender, 1 receiver
  int stretch_left [2] = '{0, 0};
  bit stretch_fast [2] = '{1'b0, 1'b0};
  int send_gap;
  int recv_stall;
  int hold_left;
  bit hold_done = 1'b0;

  int err_count     = 0;
  int n_requests    = 0;
  int n_results     = 0;
  int n_accept      = 0;
  int n_full        = 0;
  int n_idle        = 0;
  int n_done        = 0;
  int n_preempt     = 0;
  int n_cfg_writes  = 0;
  int quiet_cycles  = 0;

  function automatic logic [TIME_W-1:0] time_sat_add(logic [TIME_W-1:0] a, logic [47:0] b);
    logic [48:0] sum;
    sum = {17'd0, a} + {1'b0, b};
    return (sum > 49'h0_FFFF_FFFF) ? '1 : sum[TIME_W-1:0];
  endfunction

  // Earliest deadline among used slots, lowest slot on ties; -1 when none
  function automatic int earliest_slot(int skip);
    int best;
    best = -1;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (tbl_used[i] && i != skip) begin
        if (best < 0 || tbl_deadline[i] < tbl_deadline[best]) best = i;
      end
    end
    return best;
  endfunction

  // Advance the table model by one request and return the predicted response
  function automatic sched_rsp_t edf_schedule_step(sched_req_t it);
    sched_rsp_t          r;
    int                  slot;
    logic [BURST_W-1:0]  need;
    logic [47:0]         span;
    r = '0;
    if (it.req_type == REQ_ARRIVAL) begin
      need = (it.burst_length == '0) ? BURST_W'(1) : it.burst_length;
      slot = -1;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (!tbl_used[i] && slot < 0) slot = i;
      end
      if (slot < 0) begin
        r.status = ST_FULL;
      end else begin
        span = need * factor_model;
        tbl_used[slot]     = 1'b1;
        tbl_id[slot]       = it.task_id;
        tbl_left[slot]     = need;
        tbl_arrival[slot]  = clock_now;
        tbl_deadline[slot] = time_sat_add(clock_now, span);
        r.status = ST_ACCEPT;
      end
    end else begin
      if (cpu_busy && !tbl_used[cpu_slot]) cpu_busy = 1'b0;
      // preempt only on a strictly earlier deadline
      if (cpu_busy) begin
        slot = earliest_slot(cpu_slot);
        if (slot >= 0 && tbl_deadline[slot] < tbl_deadline[cpu_slot]) begin
          cpu_busy = 1'b0;
          n_preempt++;
        end
      end
      if (!cpu_busy) begin
        slot = earliest_slot(-1);
        if (slot >= 0) begin
          cpu_busy = 1'b1;
          cpu_slot = slot;
        end
      end
      if (cpu_busy) begin
        r.status = ST_RAN;
        r.run_id = tbl_id[cpu_slot];
        if (tbl_left[cpu_slot] <= 1) begin
          tbl_left[cpu_slot] = '0;
          tbl_used[cpu_slot] = 1'b0;
          cpu_busy     = 1'b0;
          r.completed  = 1'b1;
          r.turnaround = time_sat_add(clock_now, 48'd1) - tbl_arrival[cpu_slot];
        end else begin
          tbl_left[cpu_slot] = tbl_left[cpu_slot] - 1'b1;
        end
      end else begin
        r.status = ST_IDLE;
      end
      clock_now = time_sat_add(clock_now, 48'd1);
    end
    r.time_now = clock_now;
    return r;
  endfunction

  // Wait cycles for one transaction; stretches of zero wait come and go
  function automatic int draw_wait(int side);
    if (stretch_left[side] == 0) begin
      stretch_left[side] = $urandom_range(16, 96);
      stretch_fast[side] = ($urandom_range(0, 3) == 0);
    end
    stretch_left[side]--;
    return stretch_fast[side] ? 0 : $urandom_range(0, WAIT_MAX);
  endfunction

  function automatic void queue_item(logic kind, logic [TASK_ID_W-1:0] id,
                                     logic [BURST_W-1:0] burst);
    sched_req_t it;
    it.req_type     = kind;
    it.task_id      = id;
    it.burst_length = burst;
    req_backlog = {req_backlog, it};
  endfunction

  // Random request; mostly short bursts so tasks finish and slots recycle
  function automatic void queue_random(int arrive_pct);
    sched_req_t it;
    int         pick;
    it.task_id      = TASK_ID_W'($urandom_range(0, 255));
    it.burst_length = BURST_W'($urandom);
    it.req_type     = ($urandom_range(0, 99) < arrive_pct) ? REQ_ARRIVAL : REQ_TICK;
    if (it.req_type == REQ_ARRIVAL) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) it.burst_length = '0;
      else if (pick < 85) it.burst_length = BURST_W'($urandom_range(1, 6));
      else it.burst_length = BURST_W'($urandom_range(7, 40));
    end
    req_backlog = {req_backlog, it};
  endfunction

  function automatic void check_result(sched_rsp_t got);
    sched_rsp_t want;
    if (sched_result_q.size() == 0) begin
      err_count++;
      if (err_count <= REPORT_MAX)
        $display("ERROR: unexpected response status=%0d run_id=%0d time_now=%0d",
                 got.status, got.run_id, got.time_now);
      return;
    end
    want = sched_result_q.pop_front();
    case (want.status)
      ST_ACCEPT: n_accept++;
      ST_FULL:   n_full++;
      ST_IDLE:   n_idle++;
      default:   if (want.completed) n_done++;
    endcase
    if (got.status !== want.status || got.run_id !== want.run_id ||
        got.completed !== want.completed || got.turnaround !== want.turnaround ||
        got.time_now !== want.time_now) begin
      err_count++;
      if (err_count <= REPORT_MAX)
        $display({"ERROR: response %0d mismatch: status %0d/%0d run_id %0d/%0d ",
                  "completed %0d/%0d turnaround %0d/%0d time_now %0d/%0d (exp/got)"},
                 n_results, want.status, got.status, want.run_id, got.run_id,
                 want.completed, got.completed, want.turnaround, got.turnaround,
                 want.time_now, got.time_now);
    end
  endfunction

  // Request driver: one transaction at a time from the backlog
  always @(posedge clk) begin
    bit offering;
    if (rst) begin
      req_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      offering = req_ch.valid;
      if (req_ch.valid && req_ch.ready) begin
        sched_result_q = {sched_result_q, edf_schedule_step(req_live)};
        n_requests++;
        offering = 1'b0;
        send_gap = draw_wait(0);
      end
      if (!offering) begin
        if (send_gap == 0 && req_backlog.size() != 0) begin
          req_live = req_backlog.pop_front();
          req_ch.valid        <= 1'b1;
          req_ch.req_type     <= req_live.req_type;
          req_ch.task_id      <= req_live.task_id;
          req_ch.burst_length <= req_live.burst_length;
        end else begin
          req_ch.valid <= 1'b0;
          if (send_gap > 0) send_gap--;
        end
      end
    end
  end

  // Response monitor with random stalls and one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      recv_stall = 0;
      hold_left  = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        check_result(sched_rsp_t'{status: rsp_ch.status, run_id: rsp_ch.run_id,
                                  completed: rsp_ch.completed,
                                  turnaround: rsp_ch.turnaround,
                                  time_now: rsp_ch.time_now});
        n_results++;
        recv_stall = draw_wait(1);
        if (n_results == HOLD_AT && !hold_done) begin
          hold_left = HOLD_CYCLES;
          hold_done = 1'b1;
        end
      end
      if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else if (recv_stall > 0) begin
        rsp_ch.ready <= 1'b0;
        recv_stall--;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("ERROR: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (req_backlog.size() != 0 || req_ch.valid || sched_result_q.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_factor(input logic [FACTOR_W-1:0] value);
    @(posedge clk);
    cfg_ch.valid           <= 1'b1;
    cfg_ch.deadline_factor <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    factor_model = value;
    n_cfg_writes++;
  endtask

  // Main sequence
  initial begin
    int                  arrive_pct;
    logic [FACTOR_W-1:0] phase_factor;
    rst                 = 1'b1;
    cfg_ch.valid        = 1'b0;
    cfg_ch.deadline_factor = FACTOR_RESET;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      tbl_used[i]     = 1'b0;
      tbl_id[i]       = '0;
      tbl_left[i]     = '0;
      tbl_deadline[i] = '0;
      tbl_arrival[i]  = '0;
    end
    clock_now    = '0;
    cpu_busy     = 1'b0;
    cpu_slot     = 0;
    factor_model = FACTOR_RESET;

    // Directed: idle tick, zero burst, then fill the table past full
    queue_item(REQ_TICK, 8'h00, 16'h0000);
    queue_item(REQ_ARRIVAL, 8'h00, 16'h0000);
    queue_item(REQ_TICK, 8'hFF, 16'hFFFF);
    for (int i = 0; i < NUM_SLOTS; i++)
      queue_item(REQ_ARRIVAL, 8'(i * 17), 16'((i % 4) + 1));
    queue_item(REQ_ARRIVAL, 8'hFF, 16'hFFFF);
    for (int i = 0; i < 4; i++) queue_item(REQ_TICK, 8'h5A, 16'hA5A5);
    queue_item(REQ_ARRIVAL, 8'h3C, 16'h0001);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Random phases, one deadline factor each; first runs at the reset factor
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        case (ph)
          1:       phase_factor = 4'd15;
          2:       phase_factor = 4'd0;
          3:       phase_factor = 4'd1;
          default: phase_factor = FACTOR_W'($urandom_range(3, 14));
        endcase
        wait_drained();
        write_factor(phase_factor);
      end
      arrive_pct = $urandom_range(15, 50);
      for (int k = 0; k < RANDOM_ITEMS / NUM_PHASES; k++) queue_random(arrive_pct);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    err_count += sched_result_q.size();

    $display("Run covered %0d requests over %0d factor writes: %0d accepted, %0d full,",
             n_requests, n_cfg_writes, n_accept, n_full);
    $display("  %0d idle ticks, %0d completions, %0d preemptions; %0d errors",
             n_idle, n_done, n_preempt, err_count);
    if (err_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/edfs_pkg.sv
rtl/core/edfs_ifs.sv
rtl/core/edfs_slot_store.sv
rtl/core/edf_preemptive_scheduler.sv
tb/edf_preemptive_scheduler_tb.sv
